[hdl/tspr_pkg.sv]
// Shared types, constants and helper functions of the tile and sprite pixel renderer.
package tspr_pkg;

  localparam int unsigned VideoBytes     = 8192;
  localparam int unsigned VideoAw        = 13;
  localparam int unsigned SpriteCountDef = 40;
  localparam int unsigned SplDef         = 10;
  localparam int unsigned ScreenWidth    = 160;

  localparam logic [VideoAw-1:0] MapLowBase   = 13'h1800;
  localparam logic [VideoAw-1:0] MapHighBase  = 13'h1C00;
  localparam logic [VideoAw-1:0] TileSignBase = 13'h1000;
  localparam logic [7:0]         WinXMax      = 8'd166;
  localparam logic [7:0]         LastColumn   = 8'(ScreenWidth - 1);

  typedef enum logic [1:0] {
    KIND_VWRITE = 2'd0,
    KIND_SWRITE = 2'd1,
    KIND_RENDER = 2'd2,
    KIND_FRAME  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CFG_LCDC  = 3'd0,
    CFG_SCY   = 3'd1,
    CFG_SCX   = 3'd2,
    CFG_BGP   = 3'd3,
    CFG_OBP0  = 3'd4,
    CFG_OBP1  = 3'd5,
    CFG_WY    = 3'd6,
    CFG_WX    = 3'd7
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BG_MAP,
    ST_BG_IDX,
    ST_BG_LO,
    ST_BG_HI,
    ST_SCAN,
    ST_OV_Y,
    ST_OV_X,
    ST_OV_T,
    ST_OV_F,
    ST_OV_A,
    ST_OV_LO,
    ST_OV_HI,
    ST_FINISH
  } state_e;

  function automatic logic [1:0] pick_color(logic [7:0] lo, logic [7:0] hi, logic [2:0] b);
    pick_color = {hi[b], lo[b]};
  endfunction

  function automatic logic [1:0] map_shade(logic [1:0] color, logic [7:0] pal);
    logic [1:0] r;
    case (color)
      2'd0: r = pal[1:0];
      2'd1: r = pal[3:2];
      2'd2: r = pal[5:4];
      default: r = pal[7:6];
    endcase
    map_shade = r;
  endfunction

endpackage

[hdl/tspr_if.sv]
// Handshake channel interfaces of the renderer: input items, results and register writes.
interface tspr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [12:0] address;
  logic [7:0]  data;
  logic [7:0]  line;
  logic [7:0]  column;
  modport source (output valid, kind, address, data, line, column, input ready);
  modport sink (input valid, kind, address, data, line, column, output ready);
endinterface

interface tspr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] shade;
  logic [7:0] out_line;
  logic [7:0] out_column;
  modport source (output valid, shade, out_line, out_column, input ready);
  modport sink (input valid, shade, out_line, out_column, output ready);
endinterface

interface tspr_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink (input valid, index, wdata, output ready);
endinterface

[hdl/tile_sprite_pixel_renderer.sv]
// Top level of the tile map and sprite pixel renderer.
//
// Input items do one of four things: write a byte of the 8 KiB video memory (kind 0), write
// a byte of the sprite attribute table (kind 1), ask for the shade of one pixel (kind 2) or
// start a frame (kind 3, which clears the window line counter). Writes and frame starts
// finish in the cycle they are accepted and give no result. A pixel goes through a sequencer
// that shares one port of each memory. Once the map address is formed, it fetches the
// background or window tile index and the two bit planes; these fetches are skipped when
// the background layer is blank. The sprite attribute table is then scanned one Y byte per
// cycle, stopping early when SPRITES_PER_LINE sprites are found, and not at all when sprites
// are off. Each found sprite has its four attribute bytes read in states OV_Y to OV_A, and
// its pattern bytes in OV_LO and OV_HI when it covers the pixel's column. The FINISH state
// then loads the result, and no new item is accepted until the block is back in idle. The
// finished shade sits in an output register, so the next item is accepted while the result
// waits for its transfer; a pixel that finishes while the previous result still waits holds
// until that transfer. Registers are written through their own channel, which is always
// ready; the user must write them only while the block is idle; the block does not enforce
// it. Memory bytes that were never written read as unknown.
module tile_sprite_pixel_renderer
  import tspr_pkg::*;
#(
  parameter int unsigned NUM_SPRITES      = SpriteCountDef,
  parameter int unsigned SPRITES_PER_LINE = SplDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  tspr_in_if.sink    in_if,
  tspr_out_if.source out_if,
  tspr_cfg_if.sink   cfg_if
);

  localparam int unsigned TableBytes = NUM_SPRITES * 4;
  localparam int unsigned Taw = $clog2(TableBytes);
  localparam int unsigned Siw = (NUM_SPRITES > 1) ? $clog2(NUM_SPRITES) : 1;
  localparam int unsigned Scw = $clog2(NUM_SPRITES + 1);
  localparam int unsigned Nw  = $clog2(SPRITES_PER_LINE + 1);
  localparam int unsigned Fiw = (SPRITES_PER_LINE > 1) ? $clog2(SPRITES_PER_LINE) : 1;

  // Configuration registers.
  logic [7:0] lcdc_q, scy_q, scx_q, bgp_q, obp0_q, obp1_q, wy_q, wx_q;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcdc_q <= 8'd145;
      scy_q  <= 8'd0;
      scx_q  <= 8'd0;
      bgp_q  <= 8'd252;
      obp0_q <= 8'd255;
      obp1_q <= 8'd255;
      wy_q   <= 8'd0;
      wx_q   <= 8'd0;
    end else if (cfg_if.valid) begin
      case (cfg_e'(cfg_if.index))
        CFG_LCDC: lcdc_q <= cfg_if.wdata;
        CFG_SCY:  scy_q  <= cfg_if.wdata;
        CFG_SCX:  scx_q  <= cfg_if.wdata;
        CFG_BGP:  bgp_q  <= cfg_if.wdata;
        CFG_OBP0: obp0_q <= cfg_if.wdata;
        CFG_OBP1: obp1_q <= cfg_if.wdata;
        CFG_WY:   wy_q   <= cfg_if.wdata;
        CFG_WX:   wx_q   <= cfg_if.wdata;
        default: ;
      endcase
    end
  end

  // Memories.
  logic               vram_we;
  logic [VideoAw-1:0] vram_addr;
  logic [7:0]         vram_rdata;
  logic               sram_we;
  logic [Taw-1:0]     sram_addr;
  logic [7:0]         sram_rdata;

  tspr_ram #(.Depth(VideoBytes), .Width(8)) u_vram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .addr_i  (vram_addr),
    .wdata_i (in_if.data),
    .rdata_o (vram_rdata)
  );

  tspr_ram #(.Depth(TableBytes), .Width(8)) u_sram (
    .clk_i   (clk_i),
    .we_i    (sram_we),
    .addr_i  (sram_addr),
    .wdata_i (in_if.data),
    .rdata_o (sram_rdata)
  );

  // Sequencer state.
  state_e         state_q, state_d;
  logic [7:0]     line_q, line_d, col_q, col_d;
  logic [2:0]     px_q, px_d, py_q, py_d;
  logic           ovf_q, ovf_d;
  logic [7:0]     lo_q, lo_d;
  logic [1:0]     bgc_q, bgc_d, shade_q, shade_d;
  logic           win_en_q, win_en_d;
  logic [7:0]     wline_q, wline_d;
  logic [Scw-1:0] scan_q, scan_d;
  logic           chk_v_q, chk_v_d;
  logic [Siw-1:0] chk_idx_q, chk_idx_d;
  logic [Nw-1:0]  n_q, n_d, ov_q, ov_d;
  logic [Siw-1:0] found_q [SPRITES_PER_LINE];
  logic           found_we;
  logic [7:0]     spr_y_q, spr_y_d, spr_x_q, spr_x_d, spr_t_q, spr_t_d, spr_f_q, spr_f_d;
  logic [VideoAw-1:0] taddr_q, taddr_d;
  logic           out_v_q, out_v_d;
  logic [1:0]     out_shade_q, out_shade_d;
  logic [7:0]     out_line_q, out_line_d, out_col_q, out_col_d;

  // Combinational helpers.
  logic           lcd_on, bg_en, win_en, use_win, tall;
  logic [8:0]     win_px;
  logic [8:0]     map_px;
  logic [7:0]     map_py;
  logic [13:0]    map_sum;
  logic [7:0]     tidx;
  logic [11:0]    tbase;
  logic [VideoAw-1:0] taddr;
  logic [8:0]     l16, y_top;
  logic           y_hit;
  logic [Nw-1:0]  n_after;
  logic           issue;
  logic [Siw-1:0] cur_idx;
  logic [Nw-1:0]  ov_m1;
  logic [3:0]     row, rowf;
  logic [7:0]     tile_eff;
  logic [8:0]     c8;
  logic           x_hit;
  logic [2:0]     spx;
  logic [1:0]     scol;
  logic           out_free;

  assign lcd_on  = lcdc_q[7];
  assign bg_en   = lcdc_q[0];
  assign tall    = lcdc_q[2];
  assign win_en  = bg_en && lcdc_q[5] && (wx_q <= WinXMax) && (wy_q <= line_q);
  assign use_win = win_en && (({1'b0, col_q} + 9'd7) >= {1'b0, wx_q});
  assign win_px  = {1'b0, col_q} + 9'd7 - {1'b0, wx_q};
  assign map_px  = use_win ? win_px : {1'b0, col_q + scx_q};
  assign map_py  = use_win ? wline_q : (line_q + scy_q);
  assign map_sum = 14'((use_win ? (lcdc_q[6] ? MapHighBase : MapLowBase)
                                : (lcdc_q[3] ? MapHighBase : MapLowBase)))
                 + 14'({map_py[7:3], 5'd0}) + 14'(map_px[8:3]);

  // A window map read that runs past the end of video memory returns all ones.
  assign tidx  = ovf_q ? 8'hFF : vram_rdata;
  assign tbase = {tidx, 4'd0};
  assign taddr = ((lcdc_q[4] || tidx[7]) ? 13'(tbase) : (TileSignBase + 13'(tbase)))
               + 13'({py_q, 1'b0});

  assign l16   = {1'b0, line_q} + 9'd16;
  assign y_top = {1'b0, sram_rdata} + (tall ? 9'd16 : 9'd8);
  assign y_hit = (l16 >= {1'b0, sram_rdata}) && (l16 < y_top);

  assign n_after = n_q + Nw'(chk_v_q && y_hit);
  assign issue   = (scan_q < Scw'(NUM_SPRITES)) && (n_after < Nw'(SPRITES_PER_LINE));
  assign ov_m1   = ov_q - Nw'(1);
  assign cur_idx = found_q[ov_m1[Fiw-1:0]];

  assign row      = 4'(l16 - {1'b0, spr_y_q});
  assign rowf     = sram_rdata[6] ? {tall & ~row[3], ~row[2:0]} : row;
  assign tile_eff = tall ? {spr_t_q[7:1], 1'b0} : spr_t_q;
  assign c8       = {1'b0, col_q} + 9'd8;
  assign x_hit    = (c8 >= {1'b0, spr_x_q}) && (col_q < spr_x_q);
  assign spx      = 3'(c8 - {1'b0, spr_x_q});
  assign scol     = pick_color(lo_q, vram_rdata, px_q);
  assign out_free = !out_v_q || out_if.ready;

  always_comb begin
    state_d     = state_q;
    line_d      = line_q;
    col_d       = col_q;
    px_d        = px_q;
    py_d        = py_q;
    ovf_d       = ovf_q;
    lo_d        = lo_q;
    bgc_d       = bgc_q;
    shade_d     = shade_q;
    win_en_d    = win_en_q;
    wline_d     = wline_q;
    scan_d      = scan_q;
    chk_v_d     = 1'b0;
    chk_idx_d   = chk_idx_q;
    n_d         = n_q;
    ov_d        = ov_q;
    spr_y_d     = spr_y_q;
    spr_x_d     = spr_x_q;
    spr_t_d     = spr_t_q;
    spr_f_d     = spr_f_q;
    taddr_d     = taddr_q;
    out_v_d     = out_v_q && !out_if.ready;
    out_shade_d = out_shade_q;
    out_line_d  = out_line_q;
    out_col_d   = out_col_q;
    found_we    = 1'b0;
    vram_we     = 1'b0;
    vram_addr   = in_if.address;
    sram_we     = 1'b0;
    sram_addr   = in_if.address[Taw-1:0];
    in_if.ready = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (in_if.valid) begin
          case (kind_e'(in_if.kind))
            KIND_VWRITE: vram_we = 1'b1;
            KIND_SWRITE: sram_we = (in_if.address < 13'(TableBytes));
            KIND_FRAME:  wline_d = 8'd0;
            KIND_RENDER: begin
              line_d  = in_if.line;
              col_d   = in_if.column;
              state_d = ST_BG_MAP;
            end
            default: ;
          endcase
        end
      end
      ST_BG_MAP: begin
        win_en_d  = lcd_on && win_en;
        bgc_d     = 2'd0;
        shade_d   = lcd_on ? bgp_q[1:0] : 2'd0;
        px_d      = map_px[2:0];
        py_d      = map_py[2:0];
        ovf_d     = map_sum[13];
        vram_addr = map_sum[12:0];
        scan_d    = '0;
        n_d       = '0;
        if (lcd_on && (use_win || bg_en)) begin
          state_d = ST_BG_IDX;
        end else begin
          state_d = lcdc_q[1] ? ST_SCAN : ST_FINISH;
        end
      end
      ST_BG_IDX: begin
        // The tile index is only on the read port in this cycle, so its address is kept.
        taddr_d   = taddr;
        vram_addr = taddr;
        state_d   = ST_BG_LO;
      end
      ST_BG_LO: begin
        lo_d      = vram_rdata;
        vram_addr = taddr_q + 13'd1;
        state_d   = ST_BG_HI;
      end
      ST_BG_HI: begin
        bgc_d   = pick_color(lo_q, vram_rdata, ~px_q);
        shade_d = map_shade(pick_color(lo_q, vram_rdata, ~px_q), bgp_q);
        state_d = lcdc_q[1] ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        // One Y byte is read per cycle while the one read before it is checked.
        found_we  = chk_v_q && y_hit;
        n_d       = n_after;
        sram_addr = Taw'({scan_q[Siw-1:0], 2'd0});
        if (issue) begin
          chk_v_d   = 1'b1;
          chk_idx_d = scan_q[Siw-1:0];
          scan_d    = scan_q + Scw'(1);
        end else begin
          ov_d    = n_after;
          state_d = (n_after == '0) ? ST_FINISH : ST_OV_Y;
        end
      end
      ST_OV_Y: begin
        sram_addr = Taw'({cur_idx, 2'd0});
        state_d   = ST_OV_X;
      end
      ST_OV_X: begin
        spr_y_d   = sram_rdata;
        sram_addr = Taw'({cur_idx, 2'd1});
        state_d   = ST_OV_T;
      end
      ST_OV_T: begin
        spr_x_d   = sram_rdata;
        sram_addr = Taw'({cur_idx, 2'd2});
        state_d   = ST_OV_F;
      end
      ST_OV_F: begin
        spr_t_d   = sram_rdata;
        sram_addr = Taw'({cur_idx, 2'd3});
        state_d   = ST_OV_A;
      end
      ST_OV_A: begin
        // The flags byte is read straight off the port here; the pattern address that
        // depends on it is kept for the second bit plane.
        spr_f_d   = sram_rdata;
        px_d      = sram_rdata[5] ? spx : ~spx;
        taddr_d   = 13'({tile_eff, 4'd0}) + 13'({rowf, 1'b0});
        vram_addr = taddr_d;
        if (x_hit) begin
          state_d = ST_OV_LO;
        end else begin
          ov_d    = ov_m1;
          state_d = (ov_m1 == '0) ? ST_FINISH : ST_OV_Y;
        end
      end
      ST_OV_LO: begin
        lo_d      = vram_rdata;
        vram_addr = taddr_q + 13'd1;
        state_d   = ST_OV_HI;
      end
      ST_OV_HI: begin
        if ((scol != 2'd0) && !(spr_f_q[7] && (bgc_q != 2'd0))) begin
          shade_d = map_shade(scol, spr_f_q[4] ? obp1_q : obp0_q);
        end
        ov_d    = ov_m1;
        state_d = (ov_m1 == '0) ? ST_FINISH : ST_OV_Y;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_v_d     = 1'b1;
          out_shade_d = shade_q;
          out_line_d  = line_q;
          out_col_d   = col_q;
          if (win_en_q && (col_q == LastColumn)) begin
            wline_d = wline_q + 8'd1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state is reset; the datapath registers are always loaded before they are used.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      wline_q  <= 8'd0;
      out_v_q  <= 1'b0;
      chk_v_q  <= 1'b0;
      n_q      <= '0;
      ov_q     <= '0;
      scan_q   <= '0;
      win_en_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      wline_q  <= wline_d;
      out_v_q  <= out_v_d;
      chk_v_q  <= chk_v_d;
      n_q      <= n_d;
      ov_q     <= ov_d;
      scan_q   <= scan_d;
      win_en_q <= win_en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    line_q      <= line_d;
    col_q       <= col_d;
    px_q        <= px_d;
    py_q        <= py_d;
    ovf_q       <= ovf_d;
    lo_q        <= lo_d;
    bgc_q       <= bgc_d;
    shade_q     <= shade_d;
    chk_idx_q   <= chk_idx_d;
    spr_y_q     <= spr_y_d;
    spr_x_q     <= spr_x_d;
    spr_t_q     <= spr_t_d;
    spr_f_q     <= spr_f_d;
    taddr_q     <= taddr_d;
    out_shade_q <= out_shade_d;
    out_line_q  <= out_line_d;
    out_col_q   <= out_col_d;
    if (found_we) begin
      found_q[n_q[Fiw-1:0]] <= chk_idx_q;
    end
  end

  assign out_if.valid      = out_v_q;
  assign out_if.shade      = out_shade_q;
  assign out_if.out_line   = out_line_q;
  assign out_if.out_column = out_col_q;

`ifndef SYNTHESIS
  a_found_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= Nw'(SPRITES_PER_LINE))
    else $error("found sprite count exceeds the per-line limit");

  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && out_free) |=> (out_v_q && state_q == ST_IDLE))
    else $error("finished pixel was not loaded into the output register");

  a_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (!vram_we && !sram_we))
    else $error("memory write while a pixel is in progress");
`endif

endmodule

[hdl/tspr_ram.sv]
// Single-port synchronous RAM with a registered read.
module tspr_ram #(
  parameter int unsigned Depth = 8192,
  parameter int unsigned Width = 8,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule
